FILE: rtl/ccg_pkg.sv
// Shared constants, codes and types of the core count governor.
package ccg_pkg;

   localparam int CORES         = 8;
   localparam int BOOST_HOLD_MS = 350;
   localparam int CORE_IDX_W    = $clog2(CORES);
   localparam int MASK_W        = 8;
   localparam int COUNT_W       = 4;
   localparam int RUNQ_W        = 14;
   localparam int LOAD_W        = 7;

   localparam logic [2:0] ACT_SAMPLE  = 3'd0;
   localparam logic [2:0] ACT_BOOST   = 3'd1;
   localparam logic [2:0] ACT_SUSPEND = 3'd2;
   localparam logic [2:0] ACT_RESUME  = 3'd3;
   localparam logic [2:0] ACT_DISABLE = 3'd4;
   localparam logic [2:0] ACT_ENABLE  = 3'd5;

   localparam logic [2:0] DEC_NONE    = 3'd0;
   localparam logic [2:0] DEC_ALL_UP  = 3'd1;
   localparam logic [2:0] DEC_ADD     = 3'd2;
   localparam logic [2:0] DEC_REMOVE  = 3'd3;
   localparam logic [2:0] DEC_TO_MIN  = 3'd4;
   localparam logic [2:0] DEC_BOOSTED = 3'd5;
   localparam logic [2:0] DEC_REFUSED = 3'd6;

   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_RAISE  = 3'd1;
   localparam logic [2:0] MODE_LOWER  = 3'd2;
   localparam logic [2:0] MODE_ADD    = 3'd3;
   localparam logic [2:0] MODE_REMOVE = 3'd4;

   localparam logic [2:0] REG_RUNQ_ALL_UP       = 3'd0;
   localparam logic [2:0] REG_RUNQ_ADD_ONE      = 3'd1;
   localparam logic [2:0] REG_RUNQ_REMOVE_UPPER = 3'd2;
   localparam logic [2:0] REG_RUNQ_FLOOR        = 3'd3;
   localparam logic [2:0] REG_LOAD_ALL_UP       = 3'd4;
   localparam logic [2:0] REG_LOAD_ADD_ONE      = 3'd5;
   localparam logic [2:0] REG_LOAD_REMOVE_UPPER = 3'd6;
   localparam logic [2:0] REG_LOAD_FLOOR        = 3'd7;

   typedef struct packed {
      logic [RUNQ_W-1:0] runq_all_up;
      logic [RUNQ_W-1:0] runq_add_one;
      logic [RUNQ_W-1:0] runq_remove_upper;
      logic [RUNQ_W-1:0] runq_floor;
      logic [LOAD_W-1:0] load_all_up;
      logic [LOAD_W-1:0] load_add_one;
      logic [LOAD_W-1:0] load_remove_upper;
      logic [LOAD_W-1:0] load_floor;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [RUNQ_W-1:0]  runq_avg;
      logic [LOAD_W-1:0]  load_pct;
      logic [31:0]        now_ms;
      logic [MASK_W-1:0]  allowed_cores;
      logic [COUNT_W-1:0] min_cores;
      logic [COUNT_W-1:0] max_cores;
      logic [COUNT_W-1:0] boost_cores;
   } item_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [COUNT_W-1:0] limit;
      logic [2:0]         decision;
      logic               set_suspended;
      logic               clr_suspended;
      logic               set_inactive;
      logic               set_active;
      logic               boost_grant;
   } plan_type;

endpackage

FILE: rtl/core_count_governor_unit.sv
// Top level of the core count governor: transfer handshakes, settings and the per-core walk.
// The block takes one item at a time. After the input transfer it classifies the item
// in a decide state, then walks the nonboot cores one per cycle through a single
// shared step unit (ending early once the count limit or the target core is reached,
// and skipped when no walk mode is planned), then loads the result register in a
// finishing step. The input is ready again once the finishing step has loaded the result.
// A result waiting in the output register still lets the next input transfer in, but
// that item's finishing step then waits for as long as the waiting result stays stalled.
module core_count_governor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [13:0] req_runq_avg,
   input  logic [6:0]  req_load_pct,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_allowed_cores,
   input  logic [3:0]  req_min_cores,
   input  logic [3:0]  req_max_cores,
   input  logic [3:0]  req_boost_cores,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_online_cores,
   output logic [3:0]  rsp_online_count,
   output logic [2:0]  rsp_decision,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECIDE = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [ccg_pkg::CORE_IDX_W-1:0] FIRST_CORE = ccg_pkg::CORE_IDX_W'(1);
   localparam logic [ccg_pkg::CORE_IDX_W-1:0] LAST_CORE  =
      ccg_pkg::CORE_IDX_W'(ccg_pkg::CORES - 1);

   logic [1:0]                     state_ff, state_in;
   ccg_pkg::cfg_type               cfg_ff, cfg_in;
   ccg_pkg::item_type              item_ff, item_in;
   ccg_pkg::plan_type              plan_ff, plan_in;
   ccg_pkg::plan_type              plan_w;
   logic [ccg_pkg::MASK_W-1:0]     mask_ff, mask_in;
   logic [ccg_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [ccg_pkg::CORE_IDX_W-1:0] core_ff, core_in;
   logic                           suspended_ff, suspended_in;
   logic                           active_ff, active_in;
   logic [31:0]                    boost_stamp_ff, boost_stamp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ccg_pkg::MASK_W-1:0]     rsp_online_cores_ff, rsp_online_cores_in;
   logic [ccg_pkg::COUNT_W-1:0]    rsp_online_count_ff, rsp_online_count_in;
   logic [2:0]                     rsp_decision_ff, rsp_decision_in;
   logic                           core_on;
   logic                           core_allowed;
   logic                           last_core;
   logic                           walk_done;

   ccg_decide u_decide (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .active     (active_ff),
      .suspended  (suspended_ff),
      .boost_stamp(boost_stamp_ff),
      .plan       (plan_w)
   );

   assign req_stall = (state_ff != ST_IDLE);

   assign core_on      = mask_ff[core_ff];
   assign core_allowed = item_ff.allowed_cores[core_ff];
   assign last_core    = (core_ff == LAST_CORE);

   always_comb begin
      state_in            = state_ff;
      cfg_in              = cfg_ff;
      item_in             = item_ff;
      plan_in             = plan_ff;
      mask_in             = mask_ff;
      count_in            = count_ff;
      core_in             = core_ff;
      suspended_in        = suspended_ff;
      active_in           = active_ff;
      boost_stamp_in      = boost_stamp_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_online_cores_in = rsp_online_cores_ff;
      rsp_online_count_in = rsp_online_count_ff;
      rsp_decision_in     = rsp_decision_ff;
      walk_done           = 1'b0;

      if (csr_we) begin
         case (csr_index)
            ccg_pkg::REG_RUNQ_ALL_UP:       cfg_in.runq_all_up       = csr_wdata;
            ccg_pkg::REG_RUNQ_ADD_ONE:      cfg_in.runq_add_one      = csr_wdata;
            ccg_pkg::REG_RUNQ_REMOVE_UPPER: cfg_in.runq_remove_upper = csr_wdata;
            ccg_pkg::REG_RUNQ_FLOOR:        cfg_in.runq_floor        = csr_wdata;
            ccg_pkg::REG_LOAD_ALL_UP:       cfg_in.load_all_up       = csr_wdata[6:0];
            ccg_pkg::REG_LOAD_ADD_ONE:      cfg_in.load_add_one      = csr_wdata[6:0];
            ccg_pkg::REG_LOAD_REMOVE_UPPER: cfg_in.load_remove_upper = csr_wdata[6:0];
            ccg_pkg::REG_LOAD_FLOOR:        cfg_in.load_floor        = csr_wdata[6:0];
            default:                        cfg_in                   = cfg_ff;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (plan_ff.mode)
         ccg_pkg::MODE_RAISE: begin
            if (count_ff >= plan_ff.limit) begin
               walk_done = 1'b1;
            end else begin
               if (!core_on && core_allowed) begin
                  mask_in[core_ff] = 1'b1;
                  count_in         = count_ff + 1'b1;
               end
               walk_done = last_core;
            end
         end
         ccg_pkg::MODE_LOWER: begin
            if (count_ff <= plan_ff.limit) begin
               walk_done = 1'b1;
            end else begin
               if (core_on) begin
                  mask_in[core_ff] = 1'b0;
                  count_in         = count_ff - 1'b1;
               end
               walk_done = last_core;
            end
         end
         ccg_pkg::MODE_ADD: begin
            if (!core_on) begin
               if ((count_ff < plan_ff.limit) && core_allowed) begin
                  mask_in[core_ff] = 1'b1;
                  count_in         = count_ff + 1'b1;
               end
               walk_done = 1'b1;
            end else begin
               walk_done = last_core;
            end
         end
         ccg_pkg::MODE_REMOVE: begin
            if (core_on) begin
               if (count_ff > plan_ff.limit) begin
                  mask_in[core_ff] = 1'b0;
                  count_in         = count_ff - 1'b1;
               end
               walk_done = 1'b1;
            end else begin
               walk_done = last_core;
            end
         end
         default: begin
            walk_done = 1'b1;
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            mask_in  = mask_ff;
            count_in = count_ff;
            if (req_valid) begin
               item_in.action        = req_action;
               item_in.runq_avg      = req_runq_avg;
               item_in.load_pct      = req_load_pct;
               item_in.now_ms        = req_now_ms;
               item_in.allowed_cores = req_allowed_cores;
               item_in.min_cores     = req_min_cores;
               item_in.max_cores     = req_max_cores;
               item_in.boost_cores   = req_boost_cores;
               state_in              = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            mask_in  = mask_ff;
            count_in = count_ff;
            plan_in  = plan_w;
            core_in  = FIRST_CORE;
            if (plan_w.set_suspended) begin
               suspended_in = 1'b1;
            end
            if (plan_w.clr_suspended) begin
               suspended_in = 1'b0;
            end
            if (plan_w.set_inactive) begin
               active_in = 1'b0;
            end
            if (plan_w.set_active) begin
               active_in = 1'b1;
            end
            if (plan_w.boost_grant) begin
               boost_stamp_in = item_ff.now_ms;
            end
            if (plan_w.mode == ccg_pkg::MODE_NONE) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            core_in = core_ff + 1'b1;
            if (walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            mask_in  = mask_ff;
            count_in = count_ff;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_online_cores_in = mask_ff;
               rsp_online_count_in = count_ff;
               rsp_decision_in     = plan_ff.decision;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                   <= ST_IDLE;
         cfg_ff.runq_all_up         <= 14'd975;
         cfg_ff.runq_add_one        <= 14'd280;
         cfg_ff.runq_remove_upper   <= 14'd190;
         cfg_ff.runq_floor          <= 14'd95;
         cfg_ff.load_all_up         <= 7'd65;
         cfg_ff.load_add_one        <= 7'd50;
         cfg_ff.load_remove_upper   <= 7'd35;
         cfg_ff.load_floor          <= 7'd20;
         mask_ff                    <= ccg_pkg::MASK_W'(1);
         count_ff                   <= ccg_pkg::COUNT_W'(1);
         suspended_ff               <= 1'b0;
         active_ff                  <= 1'b1;
         boost_stamp_ff             <= '0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         state_ff                   <= state_in;
         cfg_ff                     <= cfg_in;
         mask_ff                    <= mask_in;
         count_ff                   <= count_in;
         suspended_ff               <= suspended_in;
         active_ff                  <= active_in;
         boost_stamp_ff             <= boost_stamp_in;
         rsp_valid_ff               <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff             <= item_in;
      plan_ff             <= plan_in;
      core_ff             <= core_in;
      rsp_online_cores_ff <= rsp_online_cores_in;
      rsp_online_count_ff <= rsp_online_count_in;
      rsp_decision_ff     <= rsp_decision_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_online_cores = rsp_online_cores_ff;
   assign rsp_online_count = rsp_online_count_ff;
   assign rsp_decision     = rsp_decision_ff;

   a_boot_core_on: assert property (@(posedge clock) disable iff (reset) mask_ff[0])
      else $error("Boot core went offline.");

   a_count_tracks_mask: assert property (@(posedge clock) disable iff (reset)
      count_ff == ccg_pkg::COUNT_W'($countones(mask_ff)))
      else $error("Online count differs from the online mask.");

   a_walk_nonboot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (core_ff != '0))
      else $error("Core walk reached the boot core.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("Result transfer offered outside the finishing step.");

endmodule

FILE: rtl/ccg_decide.sv
// Classifies one item into a core walk mode, a count limit, a decision and state updates.
module ccg_decide (
   input  ccg_pkg::cfg_type  cfg,
   input  ccg_pkg::item_type item,
   input  logic              active,
   input  logic              suspended,
   input  logic [31:0]       boost_stamp,
   output ccg_pkg::plan_type plan
);

   logic [ccg_pkg::COUNT_W-1:0] boost_target;
   logic [31:0]                 since_boost;
   logic                        all_up_band;
   logic                        add_band;
   logic                        remove_band;
   logic                        floor_band;

   always_comb begin
      boost_target = item.boost_cores;
      if (boost_target < item.min_cores) begin
         boost_target = item.min_cores;
      end
      if (boost_target > item.max_cores) begin
         boost_target = item.max_cores;
      end
   end

   assign since_boost = item.now_ms - boost_stamp;

   assign all_up_band = (item.runq_avg >= cfg.runq_all_up) || (item.load_pct >= cfg.load_all_up);
   assign add_band    = ((item.runq_avg >= cfg.runq_add_one) &&
                         (item.runq_avg < cfg.runq_all_up)) ||
                        ((item.load_pct >= cfg.load_add_one) &&
                         (item.load_pct < cfg.load_all_up));
   assign remove_band = (item.runq_avg > cfg.runq_floor) &&
                        (item.runq_avg <= cfg.runq_remove_upper) &&
                        (item.load_pct > cfg.load_floor) &&
                        (item.load_pct <= cfg.load_remove_upper);
   assign floor_band  = (item.runq_avg <= cfg.runq_floor) && (item.load_pct <= cfg.load_floor);

   always_comb begin
      plan          = '0;
      plan.mode     = ccg_pkg::MODE_NONE;
      plan.decision = ccg_pkg::DEC_NONE;
      case (item.action)
         ccg_pkg::ACT_SAMPLE: begin
            if (active && !suspended) begin
               if (all_up_band) begin
                  plan.mode     = ccg_pkg::MODE_RAISE;
                  plan.limit    = item.max_cores;
                  plan.decision = ccg_pkg::DEC_ALL_UP;
               end else if (add_band) begin
                  plan.mode     = ccg_pkg::MODE_ADD;
                  plan.limit    = item.max_cores;
                  plan.decision = ccg_pkg::DEC_ADD;
               end else if (remove_band) begin
                  plan.mode     = ccg_pkg::MODE_REMOVE;
                  plan.limit    = item.min_cores;
                  plan.decision = ccg_pkg::DEC_REMOVE;
               end else if (floor_band) begin
                  plan.mode     = ccg_pkg::MODE_LOWER;
                  plan.limit    = item.min_cores;
                  plan.decision = ccg_pkg::DEC_TO_MIN;
               end
            end
         end
         ccg_pkg::ACT_BOOST: begin
            if (!active || suspended || (since_boost < 32'(ccg_pkg::BOOST_HOLD_MS))) begin
               plan.decision = ccg_pkg::DEC_REFUSED;
            end else begin
               plan.mode        = ccg_pkg::MODE_RAISE;
               plan.limit       = boost_target;
               plan.decision    = ccg_pkg::DEC_BOOSTED;
               plan.boost_grant = 1'b1;
            end
         end
         ccg_pkg::ACT_SUSPEND: begin
            plan.mode          = ccg_pkg::MODE_RAISE;
            plan.limit         = item.max_cores;
            plan.decision      = ccg_pkg::DEC_ALL_UP;
            plan.set_suspended = 1'b1;
         end
         ccg_pkg::ACT_RESUME: begin
            plan.clr_suspended = 1'b1;
         end
         ccg_pkg::ACT_DISABLE: begin
            plan.mode         = ccg_pkg::MODE_RAISE;
            plan.limit        = item.max_cores;
            plan.decision     = ccg_pkg::DEC_ALL_UP;
            plan.set_inactive = 1'b1;
         end
         ccg_pkg::ACT_ENABLE: begin
            plan.set_active = 1'b1;
         end
         default: begin
            plan.mode = ccg_pkg::MODE_NONE;
         end
      endcase
   end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for core_count_governor_unit with a model of the online core mask.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ccg_pkg::*;

   localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE_CYCLES = 14;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int PRINT_LIMIT  = 60;

   typedef struct packed {
      logic [MASK_W-1:0]  cores;
      logic [COUNT_W-1:0] count;
      logic [2:0]         decision;
   } outcome_type;

   class core_mask_tracker;
      cfg_type           cfg;
      logic [MASK_W-1:0] mask;
      bit                suspended;
      bit                active;
      logic [31:0]       boost_stamp;
      outcome_type       expected_outcomes[$];
      int                mismatches;
      int                decision_seen[8];

      function new();
         cfg.runq_all_up       = 14'd975;
         cfg.runq_add_one      = 14'd280;
         cfg.runq_remove_upper = 14'd190;
         cfg.runq_floor        = 14'd95;
         cfg.load_all_up       = 7'd65;
         cfg.load_add_one      = 7'd50;
         cfg.load_remove_upper = 7'd35;
         cfg.load_floor        = 7'd20;
         mask        = 8'h01;
         suspended   = 1'b0;
         active      = 1'b1;
         boost_stamp = 32'd0;
         mismatches  = 0;
      endfunction

      function void raise_to(int limit, logic [MASK_W-1:0] allowed);
         for (int c = 1; c < CORES; c++) begin
            if ($countones(mask) >= limit) break;
            if (mask[c]) continue;
            if (!allowed[c]) continue;
            mask[c] = 1'b1;
         end
      endfunction

      function void lower_to(int limit);
         for (int c = 1; c < CORES; c++) begin
            if ($countones(mask) <= limit) break;
            mask[c] = 1'b0;
         end
      endfunction

      function void add_lowest(int limit, logic [MASK_W-1:0] allowed);
         int c;
         c = 1;
         while (c < CORES && mask[c]) c++;
         if (c >= CORES || $countones(mask) >= limit) return;
         if (!allowed[c]) return;
         mask[c] = 1'b1;
      endfunction

      function void remove_lowest(int limit);
         int c;
         c = 1;
         while (c < CORES && !mask[c]) c++;
         if (c >= CORES || $countones(mask) <= limit) return;
         mask[c] = 1'b0;
      endfunction

      function void note_transfer(item_type it);
         logic [2:0]  decision;
         logic [31:0] since_boost;
         int          target;
         outcome_type exp;
         decision = DEC_NONE;
         since_boost = it.now_ms - boost_stamp;
         case (it.action)
            ACT_SAMPLE: begin
               if (active && !suspended) begin
                  if (it.runq_avg >= cfg.runq_all_up || it.load_pct >= cfg.load_all_up) begin
                     raise_to(int'(it.max_cores), it.allowed_cores);
                     decision = DEC_ALL_UP;
                  end else if ((it.runq_avg >= cfg.runq_add_one
                                && it.runq_avg < cfg.runq_all_up)
                               || (it.load_pct >= cfg.load_add_one
                                   && it.load_pct < cfg.load_all_up)) begin
                     add_lowest(int'(it.max_cores), it.allowed_cores);
                     decision = DEC_ADD;
                  end else if (it.runq_avg > cfg.runq_floor
                               && it.runq_avg <= cfg.runq_remove_upper
                               && it.load_pct > cfg.load_floor
                               && it.load_pct <= cfg.load_remove_upper) begin
                     remove_lowest(int'(it.min_cores));
                     decision = DEC_REMOVE;
                  end else if (it.runq_avg <= cfg.runq_floor
                               && it.load_pct <= cfg.load_floor) begin
                     lower_to(int'(it.min_cores));
                     decision = DEC_TO_MIN;
                  end
               end
            end
            ACT_BOOST: begin
               if (!active || suspended || since_boost < 32'(BOOST_HOLD_MS)) begin
                  decision = DEC_REFUSED;
               end else begin
                  target = int'(it.boost_cores);
                  if (target < int'(it.min_cores)) target = int'(it.min_cores);
                  if (target > int'(it.max_cores)) target = int'(it.max_cores);
                  raise_to(target, it.allowed_cores);
                  boost_stamp = it.now_ms;
                  decision = DEC_BOOSTED;
               end
            end
            ACT_SUSPEND: begin
               raise_to(int'(it.max_cores), it.allowed_cores);
               suspended = 1'b1;
               decision = DEC_ALL_UP;
            end
            ACT_RESUME: suspended = 1'b0;
            ACT_DISABLE: begin
               raise_to(int'(it.max_cores), it.allowed_cores);
               active = 1'b0;
               decision = DEC_ALL_UP;
            end
            ACT_ENABLE: active = 1'b1;
            default: ;
         endcase
         mask = mask | 8'h01;
         exp.cores = mask;
         exp.count = COUNT_W'($countones(mask));
         exp.decision = decision;
         decision_seen[decision]++;
         expected_outcomes.push_back(exp);
      endfunction

      function void report_mismatch(string what);
         if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type exp;
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("result %h/%0d/%0d with none expected",
                                      got.cores, got.count, got.decision));
            return;
         end
         exp = expected_outcomes.pop_front();
         if (got.cores !== exp.cores)
            report_mismatch($sformatf("online_cores %h, expected %h", got.cores, exp.cores));
         if (got.count !== exp.count)
            report_mismatch($sformatf("online_count %0d, expected %0d", got.count, exp.count));
         if (got.decision !== exp.decision)
            report_mismatch($sformatf("decision %0d, expected %0d", got.decision, exp.decision));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_SAMPLE;
   logic [13:0] req_runq_avg = '0;
   logic [6:0]  req_load_pct = '0;
   logic [31:0] req_now_ms = '0;
   logic [7:0]  req_allowed_cores = '0;
   logic [3:0]  req_min_cores = '0;
   logic [3:0]  req_max_cores = '0;
   logic [3:0]  req_boost_cores = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_online_cores;
   logic [3:0]  rsp_online_count;
   logic [2:0]  rsp_decision;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_RUNQ_ALL_UP;
   logic [13:0] csr_wdata = '0;

   core_mask_tracker tracker = new();

   bit          sender_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   bit          hold_request = 1'b0;
   int          held_cycles = 0;
   int          holds_done = 0;
   int          stall_left = 0;
   int          cycle_count = 0;
   int          transfers = 0;
   int          settings_applied = 0;
   logic [31:0] ms_now = 32'd0;

   core_count_governor_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_runq_avg(req_runq_avg), .req_load_pct(req_load_pct),
      .req_now_ms(req_now_ms), .req_allowed_cores(req_allowed_cores),
      .req_min_cores(req_min_cores), .req_max_cores(req_max_cores),
      .req_boost_cores(req_boost_cores),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_online_cores(rsp_online_cores), .rsp_online_count(rsp_online_count),
      .rsp_decision(rsp_decision),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int sender_gap();
      if (sender_quiet) return 0;
      return ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
   endfunction

   always @(posedge clock) begin
      if (hold_request) begin
         rsp_stall <= 1'b1;
         held_cycles++;
         if (held_cycles == HOLD_CYCLES) begin
            held_cycles = 0;
            hold_request = 1'b0;
            holds_done++;
         end
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_outcome({rsp_online_cores, rsp_online_count, rsp_decision});
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, tracker.expected_outcomes.size());
      $display("core_count_governor_unit verification failed");
      $finish;
   end

   task automatic send(input item_type it);
      req_valid         <= 1'b1;
      req_action        <= it.action;
      req_runq_avg      <= it.runq_avg;
      req_load_pct      <= it.load_pct;
      req_now_ms        <= it.now_ms;
      req_allowed_cores <= it.allowed_cores;
      req_min_cores     <= it.min_cores;
      req_max_cores     <= it.max_cores;
      req_boost_cores   <= it.boost_cores;
      do @(posedge clock); while (req_stall);
      tracker.note_transfer(it);
      transfers++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (tracker.expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [13:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_RUNQ_ALL_UP, c.runq_all_up);
      write_reg(REG_RUNQ_ADD_ONE, c.runq_add_one);
      write_reg(REG_RUNQ_REMOVE_UPPER, c.runq_remove_upper);
      write_reg(REG_RUNQ_FLOOR, c.runq_floor);
      write_reg(REG_LOAD_ALL_UP, {7'd0, c.load_all_up});
      write_reg(REG_LOAD_ADD_ONE, {7'd0, c.load_add_one});
      write_reg(REG_LOAD_REMOVE_UPPER, {7'd0, c.load_remove_upper});
      write_reg(REG_LOAD_FLOOR, {7'd0, c.load_floor});
      csr_we <= 1'b0;
      tracker.cfg = c;
      settings_applied++;
   endtask

   function automatic cfg_type settings_for(input int phase);
      cfg_type c;
      c = tracker.cfg;
      case (phase)
         1: c = {{4{14'd25}}, {4{7'd5}}};
         2: c = {{4{14'd10000}}, {4{7'd100}}};
         3: c = {{4{14'd25}}, {4{7'd100}}};
         4: c = {{4{14'd10000}}, {4{7'd5}}};
         5: begin
            c.runq_all_up       = 14'($urandom_range(25, 10000));
            c.runq_add_one      = 14'($urandom_range(25, 10000));
            c.runq_remove_upper = 14'($urandom_range(25, 10000));
            c.runq_floor        = 14'($urandom_range(25, 10000));
            c.load_all_up       = 7'($urandom_range(5, 100));
            c.load_add_one      = 7'($urandom_range(5, 100));
            c.load_remove_upper = 7'($urandom_range(5, 100));
            c.load_floor        = 7'($urandom_range(5, 100));
         end
         7: c = {14'd975, 14'd280, 14'd190, 14'd95, 7'd65, 7'd50, 7'd35, 7'd20};
         default: begin
            c.runq_floor        = 14'($urandom_range(25, 2500));
            c.runq_remove_upper = c.runq_floor + 14'($urandom_range(1, 2500));
            c.runq_add_one      = c.runq_remove_upper + 14'($urandom_range(1, 2500));
            c.runq_all_up       = c.runq_add_one + 14'($urandom_range(1, 2400));
            c.load_floor        = 7'($urandom_range(5, 24));
            c.load_remove_upper = c.load_floor + 7'($urandom_range(1, 25));
            c.load_add_one      = c.load_remove_upper + 7'($urandom_range(1, 25));
            c.load_all_up       = c.load_add_one + 7'($urandom_range(1, 24));
         end
      endcase
      return c;
   endfunction

   function automatic item_type make_item(input logic [2:0] action, input int runq, input int load,
                                          input logic [31:0] now, input logic [7:0] allowed,
                                          input int min_c, input int max_c, input int boost_c);
      item_type it;
      it.action        = action;
      it.runq_avg      = 14'(runq);
      it.load_pct      = 7'(load);
      it.now_ms        = now;
      it.allowed_cores = allowed;
      it.min_cores     = 4'(min_c);
      it.max_cores     = 4'(max_c);
      it.boost_cores   = 4'(boost_c);
      return it;
   endfunction

   function automatic logic [13:0] pick_runq(input int k);
      int v;
      int th;
      case (k)
         0: th = tracker.cfg.runq_all_up;
         1: th = tracker.cfg.runq_add_one;
         2: th = tracker.cfg.runq_remove_upper;
         default: th = tracker.cfg.runq_floor;
      endcase
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 16383);
         1: v = $urandom_range(0, 1) ? 16383 : 0;
         default: v = th + int'($urandom_range(0, 4)) - 2;
      endcase
      if (v < 0) v = 0;
      if (v > 16383) v = 16383;
      return 14'(v);
   endfunction

   function automatic logic [6:0] pick_load(input int k);
      int v;
      int th;
      case (k)
         0: th = tracker.cfg.load_all_up;
         1: th = tracker.cfg.load_add_one;
         2: th = tracker.cfg.load_remove_upper;
         default: th = tracker.cfg.load_floor;
      endcase
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 127);
         1: v = $urandom_range(0, 100);
         default: v = th + int'($urandom_range(0, 4)) - 2;
      endcase
      if (v < 0) v = 0;
      if (v > 127) v = 127;
      return 7'(v);
   endfunction

   function automatic item_type random_item();
      item_type it;
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      if (pick < 72) it.action = ACT_SAMPLE;
      else if (pick < 86) it.action = ACT_BOOST;
      else if (pick < 89) it.action = ACT_SUSPEND;
      else if (pick < 94) it.action = ACT_RESUME;
      else if (pick < 96) it.action = ACT_DISABLE;
      else if (pick < 99) it.action = ACT_ENABLE;
      else it.action = $urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
      k = $urandom_range(0, 3);
      it.runq_avg = pick_runq(k);
      it.load_pct = pick_load(k);
      case ($urandom_range(0, 9))
         0: ms_now = ms_now + $urandom;
         1, 2: ms_now = ms_now + $urandom_range(0, 360);
         default: ms_now = ms_now + $urandom_range(100, 700);
      endcase
      it.now_ms = ms_now;
      it.allowed_cores = ($urandom_range(0, 4) < 3) ? 8'hFF : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         it.min_cores = 4'($urandom_range(0, 15));
         it.max_cores = 4'($urandom_range(0, 15));
      end else begin
         it.min_cores = 4'($urandom_range(1, 4));
         it.max_cores = 4'($urandom_range(it.min_cores, 8));
      end
      it.boost_cores = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 8));
      return it;
   endfunction

   task automatic send_directed(input item_type it);
      send(it);
      pause_sender($urandom_range(0, 3));
   endtask

   task automatic run_directed();
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd0, 8'hFF, 1, 8, 8));
      send_directed(make_item(ACT_SAMPLE, 0, 0, 32'd10, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 975, 0, 32'd20, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 16383, 127, 32'd30, 8'hFF, 15, 15, 15));
      send_directed(make_item(ACT_SAMPLE, 190, 35, 32'd40, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 280, 0, 32'd50, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 95, 20, 32'd60, 8'hFF, 3, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 0, 50, 32'd70, 8'hFD, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 0, 50, 32'd80, 8'hFF, 1, 3, 0));
      send_directed(make_item(ACT_SAMPLE, 96, 21, 32'd90, 8'hFF, 3, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 250, 40, 32'd100, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd350, 8'hFF, 2, 5, 6));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd699, 8'hFF, 1, 8, 8));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd700, 8'hFF, 7, 4, 0));
      send_directed(make_item(ACT_SUSPEND, 0, 0, 32'd800, 8'h0F, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 16383, 100, 32'd900, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd2000, 8'hFF, 1, 8, 8));
      send_directed(make_item(ACT_DISABLE, 0, 0, 32'd2100, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_RESUME, 0, 0, 32'd2200, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 0, 0, 32'd2300, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd3000, 8'hFF, 1, 8, 8));
      send_directed(make_item(ACT_ENABLE, 0, 0, 32'd3100, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_UNUSED_LO, 16383, 127, 32'd3200, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_UNUSED_HI, 0, 0, 32'd3300, 8'hFF, 1, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 0, 0, 32'd3400, 8'hFF, 0, 8, 0));
      send_directed(make_item(ACT_SAMPLE, 975, 65, 32'd3500, 8'h00, 1, 0, 0));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'hFFFF_FFFF, 8'hFF, 15, 15, 15));
      send_directed(make_item(ACT_BOOST, 0, 0, 32'd100, 8'hFF, 1, 8, 8));
      ms_now = 32'd100;
   endtask

   task automatic run_random(input int count, input bit with_hold);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         if (with_hold && i == count / 2) hold_request = 1'b1;
         if (i % 100 == 60) wait_results();
         send(random_item());
         pause_sender(hold_request ? 0 : sender_gap());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_settings(settings_for(7));
      run_directed();
      wait_results();
      for (int phase = 0; phase < 8; phase++) begin
         apply_settings(settings_for(phase));
         run_random(222, phase == 1 || phase == 5);
         wait_results();
      end
      $display("Covered %0d transfers under %0d register settings with %0d long receiver holds.",
               transfers, settings_applied, holds_done);
      $display("Decisions: none %0d, all-up %0d, add %0d, remove %0d, to-min %0d, boost %0d/%0d.",
               tracker.decision_seen[DEC_NONE], tracker.decision_seen[DEC_ALL_UP],
               tracker.decision_seen[DEC_ADD], tracker.decision_seen[DEC_REMOVE],
               tracker.decision_seen[DEC_TO_MIN], tracker.decision_seen[DEC_BOOSTED],
               tracker.decision_seen[DEC_REFUSED]);
      if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0) begin
         $display("core_count_governor_unit verification clean");
      end else begin
         $display("core_count_governor_unit verification failed");
      end
      $finish;
   end

endmodule
